// File: rtl/rtph_pkg.sv
package rtph_pkg;

	localparam int MAX_PACKET_BYTES = 2048;
	localparam int SEQ_SPACE        = 65536;

	localparam int IDX_W     = $clog2(MAX_PACKET_BYTES + 1);
	localparam int SEQ_W     = $clog2(SEQ_SPACE);
	localparam int MAP_BIT_W = 5;
	localparam int MAP_ROW_W = SEQ_W - MAP_BIT_W;
	localparam int MAP_ROWS  = SEQ_SPACE / (2 ** MAP_BIT_W);

	localparam logic [4:0] NAL_SPS    = 5'd7;
	localparam logic [4:0] NAL_PPS    = 5'd8;
	localparam logic [4:0] NAL_EOSEQ  = 5'd10;
	localparam logic [4:0] NAL_STAP_A = 5'd24;
	localparam logic [4:0] NAL_FU_A   = 5'd28;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SPS   = 2'd1;
	localparam logic [1:0] EV_PPS   = 2'd2;
	localparam logic [1:0] EV_EOSEQ = 2'd3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       packet_last;
	} in_word_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        start_code_byte;
		logic [1:0]  event_res;
		logic [15:0] event_seq;
		logic        last_of_run;
	} out_word_t;

endpackage

// File: rtl/rtp_h264_depacketizer.sv
// channel | valid     | stall     | word
// --------+-----------+-----------+------------------------------------------
// input   | pkt_valid | pkt_stall | pkt_word (RTP byte, end-of-packet mark)
// output  | nal_valid | nal_stall | nal_word (Annex B byte / event)
//
// One input word per cycle while each makes at most one output word and nal_stall is low.
// A NAL unit's opening word makes five (start code + header); the next input waits for them.
// Path: input register, then one pass of parse logic into the output register.
// After reset the seen-sequence bitmap is cleared one 32-bit row per cycle:
// pkt_stall stays high until all 2048 rows are cleared.
// nal_stall holds the output word and, while that is full, the input register.
module rtp_h264_depacketizer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_stall,
	input  rtph_pkg::in_word_t  pkt_word,
	output logic                nal_valid,
	input  logic                nal_stall,
	output rtph_pkg::out_word_t nal_word
);
	import rtph_pkg::*;

	typedef enum logic [10:0] {
		PH_HDR       = 11'b000_0000_0001,
		PH_EXT       = 11'b000_0000_0010,
		PH_SKIP      = 11'b000_0000_0100,
		PH_PHDR      = 11'b000_0000_1000,
		PH_SINGLE    = 11'b000_0001_0000,
		PH_STAP_HI   = 11'b000_0010_0000,
		PH_STAP_LO   = 11'b000_0100_0000,
		PH_STAP_NAL  = 11'b000_1000_0000,
		PH_STAP_DATA = 11'b001_0000_0000,
		PH_FU_HDR    = 11'b010_0000_0000,
		PH_FU_DATA   = 11'b100_0000_0000
	} phase_t;

	// input register
	logic       valid_s1;
	in_word_t   word_s1;

	// parse state
	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [7:0]        fhb_q, fhb_d;
	logic [15:0]       seq_q, seq_d;
	logic [17:0]       skip_q, skip_d;
	logic [7:0]        phdr_q, phdr_d;
	logic [15:0]       unit_q, unit_d;
	logic              drop_q, drop_d;
	logic              sps_q, sps_d;
	logic              chk_q;

	// seen bitmap
	logic [31:0]          map_mem [MAP_ROWS];
	logic [31:0]          rd_row_q;
	logic [MAP_BIT_W-1:0] rd_bit_q;
	logic                 map_we;
	logic                 clr_busy_q;
	logic [MAP_ROW_W-1:0] clr_addr_q;

	// output register
	logic       pend_v_q;
	out_word_t  pend_q;
	logic [2:0] sc_left_q;

	logic       proc, out_pop, out_free, drop_eff, in_rng;
	logic       r_v, r_sc, r_bv;
	logic [7:0] r_byte;
	logic [1:0] r_ev;
	logic       nal_go, nal_emit, data_go;
	logic [7:0] nal_hdr;
	logic [4:0] hdr_type;
	logic [7:0] b;
	out_word_t  res;

	assign out_pop   = pend_v_q && !nal_stall;
	assign out_free  = !pend_v_q || (out_pop && (sc_left_q == 3'd0));
	assign proc      = valid_s1 && out_free;
	assign pkt_stall = clr_busy_q || (valid_s1 && !proc);
	assign nal_valid = pend_v_q;

	always_comb begin
		nal_word = pend_q;
		if (sc_left_q != 3'd0) begin
			nal_word.byte_valid      = 1'b1;
			nal_word.out_byte        = (sc_left_q == 3'd1) ? 8'h01 : 8'h00;
			nal_word.start_code_byte = 1'b1;
			nal_word.event_res       = EV_NONE;
			nal_word.event_seq       = '0;
			nal_word.last_of_run     = 1'b0;
		end
	end

	assign b        = word_s1.in_byte;
	assign in_rng   = idx_q < IDX_W'(MAX_PACKET_BYTES);
	assign drop_eff = drop_q || (chk_q && rd_row_q[rd_bit_q]);

	always_comb begin
		phase_d  = phase_q;
		idx_d    = idx_q;
		fhb_d    = fhb_q;
		seq_d    = seq_q;
		skip_d   = skip_q;
		phdr_d   = phdr_q;
		unit_d   = unit_q;
		drop_d   = drop_eff;
		sps_d    = sps_q;
		map_we   = 1'b0;
		nal_go   = 1'b0;
		nal_emit = 1'b0;
		nal_hdr  = b;
		hdr_type = b[4:0];
		data_go  = 1'b0;
		r_v      = 1'b0;
		r_sc     = 1'b0;
		r_bv     = 1'b0;
		r_byte   = 8'h00;
		r_ev     = EV_NONE;

		if (in_rng && !drop_eff) begin
			unique case (phase_q) inside
				PH_HDR: begin
					if (idx_q == IDX_W'(0)) begin
						fhb_d = b;
					end else if (idx_q == IDX_W'(2)) begin
						seq_d = {b, 8'h00};
					end else if (idx_q == IDX_W'(3)) begin
						seq_d  = {seq_q[15:8], b};
						map_we = 1'b1;
					end else if (idx_q == IDX_W'(11)) begin
						phase_d = fhb_q[4] ? PH_EXT : PH_PHDR;
					end
				end
				PH_EXT: begin
					if (idx_q == IDX_W'(14)) begin
						skip_d = {10'd0, b};
					end else if (idx_q == IDX_W'(15)) begin
						skip_d  = {skip_q[7:0], b, 2'b00};
						phase_d = ({skip_q[7:0], b} != 16'd0) ? PH_SKIP : PH_PHDR;
					end
				end
				PH_SKIP: begin
					skip_d = skip_q - 18'd1;
					if (skip_q == 18'd1) begin
						phase_d = PH_PHDR;
					end
				end
				PH_PHDR: begin
					phdr_d = b;
					if (b[4:0] == NAL_STAP_A) begin
						phase_d = PH_STAP_HI;
					end else if (b[4:0] == NAL_FU_A) begin
						phase_d = PH_FU_HDR;
					end else begin
						nal_go   = 1'b1;
						nal_emit = 1'b1;
						phase_d  = PH_SINGLE;
					end
				end
				PH_SINGLE, PH_FU_DATA: begin
					data_go = 1'b1;
				end
				PH_STAP_DATA: begin
					data_go = 1'b1;
					unit_d  = unit_q - 16'd1;
					if (unit_q == 16'd1) begin
						phase_d = PH_STAP_HI;
					end
				end
				PH_STAP_HI: begin
					unit_d  = {b, 8'h00};
					phase_d = PH_STAP_LO;
				end
				PH_STAP_LO: begin
					unit_d  = {unit_q[15:8], b};
					phase_d = ({unit_q[15:8], b} != 16'd0) ? PH_STAP_NAL : PH_STAP_HI;
				end
				PH_STAP_NAL: begin
					nal_go   = 1'b1;
					nal_emit = 1'b1;
					unit_d   = unit_q - 16'd1;
					phase_d  = (unit_q != 16'd1) ? PH_STAP_DATA : PH_STAP_HI;
				end
				PH_FU_HDR: begin
					nal_go   = 1'b1;
					nal_emit = b[7];
					nal_hdr  = {phdr_q[7:5], b[4:0]};
					phase_d  = PH_FU_DATA;
				end
				default: begin
				end
			endcase
		end

		if (nal_go) begin
			if (hdr_type == NAL_SPS) begin
				r_ev  = EV_SPS;
				sps_d = 1'b1;
			end else if (hdr_type == NAL_PPS) begin
				r_ev = EV_PPS;
			end else if (hdr_type == NAL_EOSEQ) begin
				r_ev = EV_EOSEQ;
			end
			if (sps_d && nal_emit) begin
				r_v    = 1'b1;
				r_sc   = 1'b1;
				r_bv   = 1'b1;
				r_byte = nal_hdr;
			end else if (r_ev != EV_NONE) begin
				r_v = 1'b1;
			end
		end
		if (data_go && sps_q) begin
			r_v    = 1'b1;
			r_bv   = 1'b1;
			r_byte = b;
		end

		if (in_rng) begin
			idx_d = idx_q + IDX_W'(1);
		end
		if (word_s1.packet_last) begin
			idx_d   = '0;
			phase_d = PH_HDR;
			drop_d  = 1'b0;
			skip_d  = '0;
			unit_d  = '0;
		end
	end

	always_comb begin
		res.byte_valid      = r_bv;
		res.out_byte        = r_byte;
		res.start_code_byte = 1'b0;
		res.event_res       = r_ev;
		res.event_seq       = (r_ev != EV_NONE) ? seq_q : 16'd0;
		res.last_of_run     = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			phase_q    <= PH_HDR;
			idx_q      <= '0;
			fhb_q      <= '0;
			seq_q      <= '0;
			skip_q     <= '0;
			phdr_q     <= '0;
			unit_q     <= '0;
			drop_q     <= 1'b0;
			sps_q      <= 1'b0;
			chk_q      <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
			pend_v_q   <= 1'b0;
			sc_left_q  <= '0;
		end else begin
			valid_s1 <= (pkt_valid && !pkt_stall) || (valid_s1 && !proc);
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + MAP_ROW_W'(1);
				if (clr_addr_q == MAP_ROW_W'(MAP_ROWS - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (proc) begin
				phase_q  <= phase_d;
				idx_q    <= idx_d;
				fhb_q    <= fhb_d;
				seq_q    <= seq_d;
				skip_q   <= skip_d;
				phdr_q   <= phdr_d;
				unit_q   <= unit_d;
				drop_q   <= drop_d;
				sps_q    <= sps_d;
				chk_q    <= map_we && !word_s1.packet_last;
				pend_v_q <= r_v;
				sc_left_q <= r_sc ? 3'd4 : 3'd0;
			end else if (out_pop) begin
				if (sc_left_q != 3'd0) begin
					sc_left_q <= sc_left_q - 3'd1;
				end else begin
					pend_v_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && !pkt_stall) begin
			word_s1 <= pkt_word;
		end
		if (proc) begin
			pend_q <= res;
		end
	end

	// bitmap: clear pass, then test-and-set on the full 16-bit sequence number
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			map_mem[clr_addr_q] <= '0;
		end else if (proc && map_we) begin
			map_mem[seq_d[SEQ_W-1:MAP_BIT_W]][seq_d[MAP_BIT_W-1:0]] <= 1'b1;
		end
		if (proc && map_we) begin
			rd_row_q <= map_mem[seq_d[SEQ_W-1:MAP_BIT_W]];
			rd_bit_q <= seq_d[MAP_BIT_W-1:0];
		end
	end

endmodule

// File: rtl/rtph_chk.sv
module rtph_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                nal_valid,
	input logic                nal_stall,
	input rtph_pkg::out_word_t nal_word
);
	import rtph_pkg::*;

	logic acc;
	assign acc = nal_valid && !nal_stall;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		nal_valid && nal_stall |=> nal_valid && $stable(nal_word))
		else $error("stalled output word changed");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !nal_word.last_of_run |=> nal_valid)
		else $error("gap inside a result run");

	a_sc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		acc && nal_word.start_code_byte && (nal_word.out_byte == 8'h00)
		|=> nal_valid && nal_word.start_code_byte)
		else $error("start code cut short");

	a_sc_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		acc && nal_word.start_code_byte && (nal_word.out_byte == 8'h01)
		|=> nal_valid && !nal_word.start_code_byte && nal_word.byte_valid)
		else $error("NAL header missing after start code");

endmodule

bind rtp_h264_depacketizer rtph_chk u_rtph_chk (.*);
